/* design/assert_macros.svh */
// Assertion macros shared by the design files.
// No dependencies; compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* design/esg_pkg.sv */
// Shared types and constants of the entropy pool seed generator.
// No dependencies.
`default_nettype none
package esg_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word      word;
        logic [2:0] nbytes;
    } t_result;

    localparam logic [2:0] MAX_BYTES = 3'd4;

    localparam t_word POOL_INIT [4] = '{32'hDEADBEEF, 32'hCAFEBABE, 32'h8BADF00D, 32'hFEEDFACE};

    localparam t_word GOLDEN_MULT = 32'd2654435761;
    localparam t_word INT_STEP    = 32'd7;
    localparam t_word EXT_REFRESH = 32'd1;
    localparam t_word INT_REFRESH = EXT_REFRESH + INT_STEP;

    // counter product increments for one refresh in each mode
    localparam t_word EXT_REFRESH_G = GOLDEN_MULT;
    localparam t_word INT_REFRESH_G = 32'(64'(INT_REFRESH) * 64'(GOLDEN_MULT));

    // internal-source seeding always starts from a zero counter
    localparam t_word INT_SEED_J   = 32'(64'(INT_STEP) * 64'(GOLDEN_MULT));
    localparam t_word INT_SEED_JIT = 32'(64'(INT_SEED_J + INT_REFRESH) * 64'(GOLDEN_MULT));

    localparam int unsigned MIX_SHL_A = 13;
    localparam int unsigned MIX_SHR   = 17;
    localparam int unsigned MIX_SHL_B = 5;

endpackage
`default_nettype wire

/* design/esg_pool.sv */
// Pool state, draw counter and single-pass seed/refresh mixing.
// Depends on esg_pkg.
`default_nettype none
module esg_pool import esg_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_jsrc,
    input  wire logic  i_step,
    input  wire t_word i_timestamp,
    output t_word      o_word,
    output logic       o_busy
);

    function automatic t_word f_mix(input t_word v);
        t_word t;
        t = v ^ (v << MIX_SHL_A);
        t = t ^ (t >> MIX_SHR);
        t = t ^ (t << MIX_SHL_B);
        return t;
    endfunction

    t_word r_pool [4];
    t_word r_dc;
    t_word r_dcg;       // always r_dc * GOLDEN_MULT once settled
    logic  r_seeded;
    logic  r_mul_pend;
    t_word r_mul_a;

    t_word w_j;
    t_word w_base;
    t_word w_d1;
    t_word w_jit;
    t_word w_pb [4];
    t_word w_pn [4];
    t_word w_prod;

    assign w_prod = r_mul_a * GOLDEN_MULT;

    always_comb begin
        w_j = i_jsrc ? INT_SEED_J : i_timestamp;
        if (r_seeded) begin
            w_pb = r_pool;
        end else begin
            w_pb[0] = r_pool[0] ^ w_j;
            for (int k = 1; k < 4; k++) begin
                w_pb[k] = r_pool[k] ^ f_mix(w_j + 32'(k));
            end
        end
        w_base = r_seeded ? r_dc : w_j;
        w_d1   = w_base + (i_jsrc ? INT_REFRESH : EXT_REFRESH);
        if (!i_jsrc) begin
            w_jit = i_timestamp;
        end else if (r_seeded) begin
            w_jit = r_dcg + INT_REFRESH_G;
        end else begin
            w_jit = INT_SEED_JIT;
        end
        w_pn[0] = f_mix(w_pb[0] ^ w_jit);
        w_pn[1] = f_mix(w_pb[1] ^ w_d1);
        w_pn[2] = f_mix(w_pb[2] + w_pn[0]);
        w_pn[3] = f_mix(w_pb[3] + w_pn[1]);
    end

    assign o_word = w_pn[0] ^ w_pn[1] ^ w_pn[2] ^ w_pn[3];
    assign o_busy = r_mul_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool     <= POOL_INIT;
            r_dc       <= '0;
            r_dcg      <= '0;
            r_seeded   <= 1'b0;
            r_mul_pend <= 1'b0;
        end else if (r_mul_pend) begin
            r_dcg      <= w_prod;
            r_mul_pend <= 1'b0;
        end else if (i_step) begin
            r_pool   <= w_pn;
            r_dc     <= w_d1;
            r_seeded <= 1'b1;
            if (i_jsrc) begin
                r_dcg <= w_jit;
            end else if (r_seeded) begin
                r_dcg <= r_dcg + EXT_REFRESH_G;
            end else begin
                r_mul_pend <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_mul_a <= w_d1;
        end
    end

endmodule
`default_nettype wire

/* design/esg_byte_out.sv */
// Result register and byte serializer, low byte first, tlast on the final byte.
// Depends on esg_pkg.
`default_nettype none
module esg_byte_out import esg_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_res,
    input  wire logic    i_tready,
    output logic         o_tvalid,
    output logic [7:0]   o_tdata,
    output logic         o_tlast,
    output logic         o_free
);

    logic       r_valid;
    t_result    r_res;
    logic [1:0] r_idx;

    assign o_tvalid = r_valid;
    assign o_tdata  = r_res.word[{r_idx, 3'b000} +: 8];
    assign o_tlast  = ({1'b0, r_idx} + 3'd1) == r_res.nbytes;
    assign o_free   = !r_valid || (i_tready && o_tlast);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= '0;
        end else if (r_valid && i_tready) begin
            if (o_tlast) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

/* design/entropy_pool_seed_generator_top.sv */
// Entropy pool seed generator: input register, pool update, byte serializer.
// Depends on esg_pkg, esg_pool, esg_byte_out and assert_macros.svh.
//
// Each request waits in the input register and is folded into the pool in one pass as it
// moves to the result register; its bytes then leave one per cycle while m_axis_tready is
// high, at most four per request (larger counts saturate to four), and a request of zero
// bytes passes through the input register and produces nothing. The seeding request in
// timestamp mode blocks the input register after it while the counter-product multiplier
// runs. A new request is taken while the previous one's bytes are still going out.
`default_nettype none
`include "assert_macros.svh"
module entropy_pool_seed_generator_top import esg_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,    // jitter_source
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // timestamp[31:0], byte_count[34:32], zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // seed_byte[7:0]
    output logic             m_axis_tlast    // last_byte
);

    logic       r_jsrc;
    logic       r_in_valid;
    t_word      r_in_ts;
    logic [2:0] r_in_cnt;

    logic       w_empty;
    logic       w_busy;
    logic       w_free;
    logic       w_advance;
    logic       w_step;
    t_word      w_word;
    t_result    w_res;

    assign w_empty       = r_in_cnt == 3'd0;
    assign w_advance     = r_in_valid && !w_busy && (w_empty || w_free);
    assign w_step        = w_advance && !w_empty;
    assign s_axis_tready = !r_in_valid || w_advance;

    assign w_res.word   = w_word;
    assign w_res.nbytes = (r_in_cnt > MAX_BYTES) ? MAX_BYTES : r_in_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jsrc     <= 1'b0;
            r_in_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_jsrc <= i_cfg_wdata;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ts  <= s_axis_tdata[31:0];
            r_in_cnt <= s_axis_tdata[34:32];
        end
    end

    esg_pool u_pool (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_jsrc      (r_jsrc),
        .i_step      (w_step),
        .i_timestamp (r_in_ts),
        .o_word      (w_word),
        .o_busy      (w_busy)
    );

    esg_byte_out u_byte_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_res    (w_res),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast),
        .o_free   (w_free)
    );

    `ASSERT_NEVER(a_step_while_mul, i_clk, i_rst_n, w_step && w_busy, "pool step during multiply")
    `ASSERT_NEVER(a_empty_loads, i_clk, i_rst_n, w_advance && w_empty && w_step, "empty item loaded")
    `ASSERT_PROP(a_run_continues, i_clk, i_rst_n, (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid, "byte run broken")
    `ASSERT_PROP(a_load_when_free, i_clk, i_rst_n, w_step |-> w_free, "result overwritten")

endmodule
`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for entropy_pool_seed_generator_top.
// Drives seed requests, predicts the pool refresh and checks each output byte.
// Depends on esg_pkg and the design files.
`timescale 1ns / 1ps
module testbench;
    import esg_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned PHASE_ITEMS = 38;

    typedef struct {
        t_word      ts;
        logic [2:0] nbytes;
    } t_seed_request;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } t_seed_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        m_tready = 1'b0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [7:0]  m_axis_tdata;
    wire         m_axis_tlast;

    entropy_pool_seed_generator_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_seed_request pending_requests[$];
    t_seed_byte    expected_bytes[$];

    // predictor state
    t_word pool_words[4] = '{32'hDEADBEEF, 32'hCAFEBABE, 32'h8BADF00D, 32'hFEEDFACE};
    t_word draw_ctr = '0;
    logic  is_seeded = 1'b0;
    logic  jitter_mode = 1'b0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned hold_left = 0;
    logic        hold_req = 1'b0;
    logic        hold_ack = 1'b0;
    logic        in_fire = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word xorshift_mix(input t_word v);
        v = v ^ (v << 13);
        v = v ^ (v >> 17);
        v = v ^ (v << 5);
        return v;
    endfunction

    function automatic t_word draw_jitter(input t_word ts);
        if (jitter_mode) begin
            draw_ctr = draw_ctr + 32'd7;
            return draw_ctr * 32'd2654435761;
        end
        return ts;
    endfunction

    task automatic predict_seed_bytes(input t_word ts, input logic [2:0] nbytes);
        int unsigned n;
        t_word       j;
        t_word       word;
        t_seed_byte  b;
        n = nbytes;
        if (n == 0) return;
        if (n > MAX_BYTES) n = MAX_BYTES;
        if (!is_seeded) begin
            j = draw_jitter(ts);
            pool_words[0] = pool_words[0] ^ j;
            pool_words[1] = pool_words[1] ^ xorshift_mix(j + 32'd1);
            pool_words[2] = pool_words[2] ^ xorshift_mix(j + 32'd2);
            pool_words[3] = pool_words[3] ^ xorshift_mix(j + 32'd3);
            draw_ctr = j;
            is_seeded = 1'b1;
        end
        draw_ctr = draw_ctr + 32'd1;
        pool_words[0] = xorshift_mix(pool_words[0] ^ draw_jitter(ts));
        pool_words[1] = xorshift_mix(pool_words[1] ^ draw_ctr);
        pool_words[2] = xorshift_mix(pool_words[2] + pool_words[0]);
        pool_words[3] = xorshift_mix(pool_words[3] + pool_words[1]);
        word = pool_words[0] ^ pool_words[1] ^ pool_words[2] ^ pool_words[3];
        for (int i = 0; i < n; i++) begin
            b.value = word[8*i +: 8];
            b.last = (i + 1 == n);
            expected_bytes.push_back(b);
        end
    endtask

    task automatic report_mismatch(input string what, input t_word got, input t_word exp);
        $display("[cycle %0d] %s: got %h expected %h", cycle_count, what, got, exp);
        mismatches++;
    endtask

    // sender
    always @(negedge i_clk) begin : request_driver
        t_seed_request req;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_fire) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                req = pending_requests.pop_front();
                s_tdata <= {5'd0, req.nbytes, req.ts};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_seed_byte exp_b;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            in_fire <= s_tvalid && s_axis_tready;
            if (i_rst_n) begin
                if (cfg_we) jitter_mode = cfg_wdata;
                if (s_tvalid && s_axis_tready)
                    predict_seed_bytes(s_tdata[31:0], s_tdata[34:32]);
                if (m_axis_tvalid && m_tready) begin
                    if (expected_bytes.size() == 0) begin
                        report_mismatch("unexpected item", {24'd0, m_axis_tdata}, '0);
                    end else begin
                        exp_b = expected_bytes.pop_front();
                        if (m_axis_tdata !== exp_b.value)
                            report_mismatch("seed_byte", {24'd0, m_axis_tdata},
                                            {24'd0, exp_b.value});
                        if (m_axis_tlast !== exp_b.last)
                            report_mismatch("last_byte", {31'd0, m_axis_tlast},
                                            {31'd0, exp_b.last});
                    end
                end
            end
        end
    end

    task automatic queue_request(input t_word ts, input logic [2:0] nbytes);
        t_seed_request req;
        req.ts = ts;
        req.nbytes = nbytes;
        pending_requests.push_back(req);
    endtask

    task automatic queue_random_request();
        int unsigned r;
        logic [2:0]  n;
        r = $urandom_range(99);
        if (r < 5) n = 3'd0;
        else if (r < 15) n = 3'($urandom_range(7, 5));
        else n = 3'($urandom_range(4, 1));
        queue_request($urandom, n);
    endtask

    task automatic wait_block_idle();
        while (pending_requests.size() != 0 || s_tvalid || expected_bytes.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        #1;
    endtask

    task automatic write_jitter_source(input logic value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
        #1;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        #1;

        // timestamp jitter; empty request before seeding must not seed
        write_jitter_source(1'b0);
        queue_request(32'h0000_0000, 3'd0);
        queue_request(32'h0000_0000, 3'd1);
        queue_request(32'hFFFF_FFFF, 3'd4);
        queue_request(32'hAAAA_AAAA, 3'd2);
        queue_request(32'h5555_5555, 3'd3);
        queue_request(32'h1234_5678, 3'd5);
        queue_request(32'h8765_4321, 3'd6);
        queue_request(32'hFFFF_FFFF, 3'd7);
        queue_request(32'h0000_0000, 3'd0);
        queue_request(32'hDEAD_BEEF, 3'd4);
        queue_request(32'h0000_0001, 3'd1);
        wait_block_idle();

        // internal counter jitter
        write_jitter_source(1'b1);
        queue_request(32'h0000_0000, 3'd1);
        queue_request(32'hFFFF_FFFF, 3'd4);
        queue_request(32'h0000_0000, 3'd0);
        queue_request(32'h0000_0005, 3'd7);
        queue_request(32'h0000_0003, 3'd2);
        queue_request(32'h0000_0123, 3'd3);
        wait_block_idle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 58; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 58; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase
            write_jitter_source(p[0]);
            if (p == 0) hold_req = ~hold_req;
            for (int k = 0; k < PHASE_ITEMS; k++) queue_random_request();
            wait_block_idle();
        end

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
